>>> design/lzsd_pkg.sv
// Package: widths, constants and controller/datapath link types for the LZSS decompressor.
`timescale 1ns / 1ps

package lzsd_pkg;

    localparam int INDEX_BITS  = 13;
    localparam int LENGTH_BITS = 4;
    localparam int BYTE_W      = 8;
    localparam int TOK_W       = INDEX_BITS + LENGTH_BITS;
    localparam int BREAK_EVEN  = (1 + INDEX_BITS + LENGTH_BITS) / 9;
    localparam int GATH_W      = $clog2(TOK_W + 1);
    localparam int BITCNT_W    = $clog2(BYTE_W + 1);
    localparam int CNT_W       = LENGTH_BITS + 1;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic clr_step;
        logic load_byte;
        logic take_bit;
        logic copy_rd;
        logic copy_wr;
        logic push_lit;
        logic push_end;
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic clear_last;
        logic bit_avail;
        logic ev_lit;
        logic ev_end;
        logic ev_match;
        logic copy_last;
        logic out_free;
    } t_status;

endpackage

>>> design/lzsd_if.sv
// Interfaces: compressed byte request channel and decompressed result channel.
`timescale 1ns / 1ps

interface lzsd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       first_of_stream;

    modport source (output valid, output in_byte, output first_of_stream, input ready);
    modport sink   (input valid, input in_byte, input first_of_stream, output ready);
endinterface

interface lzsd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       stream_end;

    modport source (output valid, output out_byte, output last_of_run, output stream_end,
                    input ready);
    modport sink   (input valid, input out_byte, input last_of_run, input stream_end,
                    output ready);
endinterface

>>> design/lzss_stream_decompress_core.sv
// LZSS stream decompressor top level (13-bit window index, 4-bit match length).
// After reset the 8192-byte history window is cleared, one byte a cycle, so no
// compressed byte is taken until the sweep is done. Each accepted byte is then
// decoded bit by bit (up to 8 bits) before the block returns to accepting. A
// literal and the end-of-stream token each add one output push, and a match
// copies 3 to 18 bytes, reading the single window memory and then writing it
// back for every byte. Results wait in an output register, and any stall
// there stalls decoding.
`timescale 1ns / 1ps

module lzss_stream_decompress_core
    import lzsd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    lzsd_in_if.sink           i_in,
    lzsd_out_if.source        o_out
);

    t_cmd    w_cmd;
    t_status w_status;
    logic    w_in_ready;

    assign i_in.ready = w_in_ready;

    lzsd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    lzsd_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_in_byte   (i_in.in_byte),
        .i_first     (i_in.first_of_stream),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_out_byte  (o_out.out_byte),
        .o_out_last  (o_out.last_of_run),
        .o_out_end   (o_out.stream_end)
    );

endmodule

>>> design/lzsd_ctrl.sv
// Controller: sequences window clear, bit decode, literal/end emission and match copy.
`timescale 1ns / 1ps

module lzsd_ctrl
    import lzsd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_BIT,
        S_LIT,
        S_END,
        S_RD,
        S_WR
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_status.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_byte = 1'b1;
                    n_state         = S_BIT;
                end
            end
            S_BIT: begin
                if (!i_status.bit_avail) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.take_bit = 1'b1;
                    priority if (i_status.ev_lit) begin
                        n_state = S_LIT;
                    end else if (i_status.ev_end) begin
                        n_state = S_END;
                    end else if (i_status.ev_match) begin
                        n_state = S_RD;
                    end else begin
                        n_state = S_BIT;
                    end
                end
            end
            S_LIT: begin
                if (i_status.out_free) begin
                    o_cmd.push_lit = 1'b1;
                    n_state        = S_BIT;
                end
            end
            S_END: begin
                if (i_status.out_free) begin
                    o_cmd.push_end = 1'b1;
                    n_state        = S_BIT;
                end
            end
            S_RD: begin
                o_cmd.copy_rd = 1'b1;
                n_state       = S_WR;
            end
            S_WR: begin
                if (i_status.out_free) begin
                    o_cmd.copy_wr = 1'b1;
                    n_state       = i_status.copy_last ? S_BIT : S_RD;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> design/lzsd_dpath.sv
// Datapath: bit gatherer, history window memory, copy pointers and output register.
`timescale 1ns / 1ps

module lzsd_dpath
    import lzsd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_status           o_status,
    input  logic [BYTE_W-1:0] i_in_byte,
    input  logic              i_first,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output logic [BYTE_W-1:0] o_out_byte,
    output logic              o_out_last,
    output logic              o_out_end
);

    localparam int WIN_DEPTH = 1 << INDEX_BITS;

    logic [BYTE_W-1:0]     r_mem [WIN_DEPTH];
    logic [BYTE_W-1:0]     r_rd_data;
    logic [INDEX_BITS-1:0] r_clr_addr;
    logic [INDEX_BITS-1:0] r_wpos;
    logic [INDEX_BITS-1:0] r_rpos;
    logic [CNT_W-1:0]      r_cnt;
    logic [BYTE_W-1:0]     r_shift;
    logic [BITCNT_W-1:0]   r_bits_left;
    logic [TOK_W-1:0]      r_token;
    logic [GATH_W-1:0]     r_gathered;
    logic                  r_in_token;
    logic                  r_is_lit;
    logic                  r_done;
    logic                  r_out_valid;
    logic [BYTE_W-1:0]     r_out_byte;
    logic                  r_out_last;
    logic                  r_out_end;

    logic                  w_bit;
    logic [TOK_W-1:0]      w_tok_next;
    logic [GATH_W-1:0]     w_gath_next;
    logic                  w_ev_lit;
    logic                  w_ev_end;
    logic                  w_ev_match;
    logic                  w_out_free;
    logic                  w_we;
    logic [INDEX_BITS-1:0] w_waddr;
    logic [BYTE_W-1:0]     w_wdata;

    assign w_bit       = r_shift[BYTE_W-1];
    assign w_tok_next  = {r_token[TOK_W-2:0], w_bit};
    assign w_gath_next = r_gathered + GATH_W'(1);
    assign w_ev_lit    = r_in_token && r_is_lit && (w_gath_next == GATH_W'(BYTE_W));
    assign w_ev_end    = r_in_token && !r_is_lit && (w_gath_next == GATH_W'(INDEX_BITS))
                         && (w_tok_next == '0);
    assign w_ev_match  = r_in_token && !r_is_lit && (w_gath_next == GATH_W'(TOK_W));
    assign w_out_free  = !r_out_valid || i_out_ready;

    assign o_status.clear_last = (r_clr_addr == '1);
    assign o_status.bit_avail  = (r_bits_left != '0) && !r_done;
    assign o_status.ev_lit     = w_ev_lit;
    assign o_status.ev_end     = w_ev_end;
    assign o_status.ev_match   = w_ev_match;
    assign o_status.copy_last  = (r_cnt == '0);
    assign o_status.out_free   = w_out_free;

    // Window write port: clear sweep, literal store, or copy write-back
    always_comb begin
        w_we    = i_cmd.clr_step || i_cmd.push_lit || i_cmd.copy_wr;
        w_waddr = r_wpos;
        w_wdata = r_rd_data;
        priority if (i_cmd.clr_step) begin
            w_waddr = r_clr_addr;
            w_wdata = '0;
        end else if (i_cmd.push_lit) begin
            w_wdata = r_token[BYTE_W-1:0];
        end else begin
            w_wdata = r_rd_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (i_cmd.copy_rd) begin
            r_rd_data <= r_mem[r_rpos];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr  <= '0;
            r_wpos      <= INDEX_BITS'(1);
            r_bits_left <= '0;
            r_token     <= '0;
            r_gathered  <= '0;
            r_in_token  <= 1'b0;
            r_is_lit    <= 1'b0;
            r_done      <= 1'b0;
            r_cnt       <= '0;
            r_rpos      <= '0;
        end else begin
            if (i_cmd.clr_step) begin
                r_clr_addr <= r_clr_addr + INDEX_BITS'(1);
            end
            if (i_cmd.load_byte) begin
                r_shift     <= i_in_byte;
                r_bits_left <= BITCNT_W'(BYTE_W);
                if (i_first) begin
                    r_wpos     <= INDEX_BITS'(1);
                    r_token    <= '0;
                    r_gathered <= '0;
                    r_in_token <= 1'b0;
                    r_is_lit   <= 1'b0;
                    r_done     <= 1'b0;
                end
            end
            if (i_cmd.take_bit) begin
                r_shift     <= {r_shift[BYTE_W-2:0], 1'b0};
                r_bits_left <= r_bits_left - BITCNT_W'(1);
                if (!r_in_token) begin
                    // flag bit opens a token
                    r_in_token <= 1'b1;
                    r_is_lit   <= w_bit;
                    r_token    <= '0;
                    r_gathered <= '0;
                end else begin
                    r_token    <= w_tok_next;
                    r_gathered <= w_gath_next;
                    if (w_ev_lit || w_ev_end || w_ev_match) begin
                        r_in_token <= 1'b0;
                    end
                    if (w_ev_end) begin
                        r_done <= 1'b1;
                    end
                    if (w_ev_match) begin
                        r_rpos <= w_tok_next[TOK_W-1:LENGTH_BITS];
                        r_cnt  <= CNT_W'(w_tok_next[LENGTH_BITS-1:0]) + CNT_W'(BREAK_EVEN);
                    end
                end
            end
            if (i_cmd.push_lit || i_cmd.copy_wr) begin
                r_wpos <= r_wpos + INDEX_BITS'(1);
            end
            if (i_cmd.copy_wr) begin
                r_rpos <= r_rpos + INDEX_BITS'(1);
                r_cnt  <= r_cnt - CNT_W'(1);
            end
        end
    end

    // Output register: hold until taken, load on any push
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.push_lit || i_cmd.push_end || i_cmd.copy_wr) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push_lit) begin
            r_out_byte <= r_token[BYTE_W-1:0];
            r_out_last <= 1'b1;
            r_out_end  <= 1'b0;
        end else if (i_cmd.push_end) begin
            r_out_byte <= '0;
            r_out_last <= 1'b1;
            r_out_end  <= 1'b1;
        end else if (i_cmd.copy_wr) begin
            r_out_byte <= r_rd_data;
            r_out_last <= (r_cnt == '0);
            r_out_end  <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_out_last  = r_out_last;
    assign o_out_end   = r_out_end;

endmodule

>>> design/lzsd_checker.sv
// Port-level checker for the LZSS decompressor, bound to the top level.
`timescale 1ns / 1ps

module lzsd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_byte,
    input logic       i_out_last,
    input logic       i_out_end
);

    // No request is taken right after reset, when the clearing sweep starts
    a_no_ready_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_in_ready)
        else $error("input ready right after reset");

    // One byte at a time: decoding follows every accepted request
    a_one_byte_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input ready in the cycle after an accepted request");

    // End result carries a zero byte and closes its run
    a_end_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_end |-> i_out_byte == 8'd0 && i_out_last)
        else $error("malformed end-of-stream result");

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_byte)
            && $stable(i_out_last) && $stable(i_out_end))
        else $error("stalled result changed");

endmodule

bind lzss_stream_decompress_core lzsd_checker u_lzsd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_byte  (o_out.out_byte),
    .i_out_last  (o_out.last_of_run),
    .i_out_end   (o_out.stream_end)
);

>>> verif/lzss_stream_decompress_core_tb.sv
// Testbench: feeds LZSS compressed streams to the decompressor and checks every decoded byte.
`timescale 1ns / 1ps
module lzss_stream_decompress_core_tb;
    import lzsd_pkg::*;

    localparam int WIN     = 1 << INDEX_BITS;
    localparam int LEN_MAX = (1 << LENGTH_BITS) - 1;

    typedef struct packed {
        logic [7:0] data;
        logic       first;
    } t_in_req;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       fin;
    } t_out_req;

    logic i_clk;
    logic i_rst_n;

    lzsd_in_if  in_ch ();
    lzsd_out_if out_ch ();

    lzss_stream_decompress_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_in_req  byte_q [$];
    t_out_req want_q [$];
    int src_idle_pct;
    int snk_stall_pct;
    int n_sent;
    int n_gen;
    int n_checked;
    int n_err;
    int n_streams;

    // decoder image
    logic [7:0]            hist [WIN];
    logic [INDEX_BITS-1:0] wr_pos;
    logic [TOK_W-1:0]      tok;
    int                    tok_n;
    bit                    in_tok;
    bit                    tok_lit;
    bit                    done;

    // stream builder
    bit sbits [$];
    int gen_wp;

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // Work out the decoded bytes one compressed byte causes.
    task automatic decode_byte(input t_in_req r);
        t_out_req              res [$];
        t_out_req              one;
        logic [INDEX_BITS-1:0] src;
        int                    total;
        bit                    b;
        if (r.first) begin
            wr_pos  = 'd1;
            tok     = '0;
            tok_n   = 0;
            in_tok  = 1'b0;
            tok_lit = 1'b0;
            done    = 1'b0;
        end
        one = '0;
        for (int k = 7; k >= 0; k--) begin
            if (done) break;
            b = r.data[k];
            if (!in_tok) begin
                in_tok  = 1'b1;
                tok_lit = b;
                tok     = '0;
                tok_n   = 0;
            end else begin
                tok = {tok[TOK_W-2:0], b};
                tok_n++;
                if (tok_lit) begin
                    if (tok_n == 8) begin
                        one.data = tok[7:0];
                        one.fin  = 1'b0;
                        res.push_back(one);
                        hist[wr_pos] = tok[7:0];
                        wr_pos++;
                        in_tok = 1'b0;
                    end
                end else if (tok_n == INDEX_BITS && tok[INDEX_BITS-1:0] == '0) begin
                    one.data = 8'h00;
                    one.fin  = 1'b1;
                    res.push_back(one);
                    done   = 1'b1;
                    in_tok = 1'b0;
                end else if (tok_n == TOK_W) begin
                    src   = tok[TOK_W-1:LENGTH_BITS];
                    total = int'(tok[LENGTH_BITS-1:0]) + BREAK_EVEN + 1;
                    one.fin = 1'b0;
                    // copy byte by byte so overlapping matches read fresh data
                    repeat (total) begin
                        one.data = hist[src];
                        res.push_back(one);
                        hist[wr_pos] = one.data;
                        wr_pos++;
                        src++;
                    end
                    in_tok = 1'b0;
                end
            end
        end
        if (res.size() > 0) begin
            one = res.pop_back();
            one.last = 1'b1;
            res.push_back(one);
        end
        foreach (res[i]) want_q.push_back(res[i]);
    endtask

    task automatic put_bits(input int unsigned v, input int n);
        for (int k = n - 1; k >= 0; k--) sbits.push_back(v[k]);
    endtask

    task automatic add_literal(input int unsigned v);
        put_bits(1, 1);
        put_bits(v, 8);
        gen_wp++;
    endtask

    task automatic add_match(input int unsigned pos, input int unsigned len);
        put_bits(0, 1);
        put_bits(pos, INDEX_BITS);
        put_bits(len, LENGTH_BITS);
        gen_wp += len + BREAK_EVEN + 1;
    endtask

    task automatic add_end();
        put_bits(0, 1 + INDEX_BITS);
    endtask

    // Point a short distance back from the builder's write position.
    function automatic int unsigned near_pos();
        int unsigned p;
        p = (gen_wp - $urandom_range(1, 24)) & (WIN - 1);
        if (p == 0) p = 1;
        return p;
    endfunction

    // Pad to a byte boundary, pack MSB first and queue with first_of_stream on byte 0.
    task automatic ship_stream();
        t_in_req r;
        int      idx;
        while (sbits.size() % 8 != 0) sbits.push_back(1'($urandom_range(1)));
        idx = 0;
        while (sbits.size() > 0) begin
            r.first = (idx == 0);
            for (int k = 7; k >= 0; k--) r.data[k] = sbits.pop_front();
            byte_q.push_back(r);
            idx++;
        end
        n_gen += idx;
        n_streams++;
    endtask

    task automatic random_stream();
        int      kind;
        t_in_req r;
        gen_wp = 1;
        repeat ($urandom_range(2, 10)) begin
            kind = $urandom_range(99);
            if (kind < 50) add_literal($urandom_range(255));
            else if (kind < 80) add_match(near_pos(), $urandom_range(LEN_MAX));
            else add_match($urandom_range(1, WIN - 1), $urandom_range(LEN_MAX));
        end
        kind = $urandom_range(99);
        if (kind < 75) begin
            add_end();
        end else if (kind < 90) begin
            // break the last token off mid-way
            repeat ($urandom_range(1, 8)) if (sbits.size() > 0) void'(sbits.pop_back());
        end
        ship_stream();
        if (kind < 75 && $urandom_range(3) == 0) begin
            repeat ($urandom_range(1, 3)) begin
                r.data  = 8'($urandom_range(255));
                r.first = 1'b0;
                byte_q.push_back(r);
                n_gen++;
            end
        end
    endtask

    // Driver: hold a request until it is taken, then predict it.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                decode_byte(byte_q.pop_front());
                n_sent++;
            end
            if (!(in_ch.valid && !in_ch.ready)) begin
                if (byte_q.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
                    in_ch.valid           <= 1'b1;
                    in_ch.in_byte         <= byte_q[0].data;
                    in_ch.first_of_stream <= byte_q[0].first;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each result request with the oldest prediction.
    always @(posedge i_clk) begin
        t_out_req seen;
        t_out_req due;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                seen.data = out_ch.out_byte;
                seen.last = out_ch.last_of_run;
                seen.fin  = out_ch.stream_end;
                if (want_q.size() == 0) begin
                    n_err++;
                    if (n_err <= 10)
                        $display("unexpected result: out_byte %h last_of_run %b stream_end %b",
                                 seen.data, seen.last, seen.fin);
                end else begin
                    due = want_q.pop_front();
                    if (seen !== due) begin
                        n_err++;
                        if (n_err <= 10)
                            $display({"result %0d mismatch (expected/actual): out_byte %h/%h ",
                                      "last_of_run %b/%b stream_end %b/%b"}, n_checked,
                                     due.data, seen.data, due.last, seen.last,
                                     due.fin, seen.fin);
                    end
                    n_checked++;
                end
            end
            out_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    initial begin
        #6_000_000;
        $display("timeout: %0d requests pending, %0d results due", byte_q.size(), want_q.size());
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        int      target;
        t_in_req r;
        i_rst_n               = 1'b0;
        in_ch.valid           = 1'b0;
        in_ch.in_byte         = 8'h00;
        in_ch.first_of_stream = 1'b0;
        out_ch.ready          = 1'b0;
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        n_sent = 0; n_gen = 0; n_checked = 0; n_err = 0; n_streams = 0;
        for (int i = 0; i < WIN; i++) hist[i] = 8'h00;
        wr_pos  = 'd1;
        tok     = '0;
        tok_n   = 0;
        in_tok  = 1'b0;
        tok_lit = 1'b0;
        done    = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 52; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 52; end
                default: begin src_idle_pct = 36; snk_stall_pct = 36; end
            endcase
            if (ph == 0) begin
                // literals at both extremes, shortest copy, overlapping copy,
                // copy from the unwritten top of the window wrapping to 0, end token
                gen_wp = 1;
                add_literal(8'hFF);
                add_literal(8'h00);
                add_literal(8'hA5);
                add_match(1, 0);
                add_match(5, LEN_MAX);
                add_match(WIN - 1, LEN_MAX);
                add_end();
                ship_stream();
                // bytes after the end token are dropped
                r = '{data: 8'hFF, first: 1'b0};
                byte_q.push_back(r);
                r = '{data: 8'h00, first: 1'b0};
                byte_q.push_back(r);
                // restart while a match is half gathered
                gen_wp = 1;
                add_literal(8'h3C);
                add_match(2, 7);
                repeat (5) void'(sbits.pop_back());
                ship_stream();
                // restarted stream still sees the old window contents
                gen_wp = 1;
                add_match(1, LEN_MAX);
                add_literal(8'h80);
                add_end();
                ship_stream();
                // end token spread over two all-zero bytes, then restart on 0xFF
                r = '{data: 8'h00, first: 1'b1};
                byte_q.push_back(r);
                r = '{data: 8'h00, first: 1'b0};
                byte_q.push_back(r);
                r = '{data: 8'hFF, first: 1'b0};
                byte_q.push_back(r);
                r = '{data: 8'hFF, first: 1'b1};
                byte_q.push_back(r);
                r = '{data: 8'hFF, first: 1'b0};
                byte_q.push_back(r);
            end
            target = n_gen + 30;
            while (n_gen < target) begin
                if ($urandom_range(99) < 85) begin
                    random_stream();
                end else begin
                    repeat ($urandom_range(1, 4)) begin
                        r.data  = 8'($urandom_range(255));
                        r.first = ($urandom_range(99) < 20);
                        byte_q.push_back(r);
                        n_gen++;
                    end
                end
            end
            // wait for the block to drain before the next phase
            while (byte_q.size() > 0 || want_q.size() > 0) @(posedge i_clk);
            repeat (60) @(posedge i_clk);
        end

        $display("Sent %0d compressed bytes over %0d streams plus noise; checked %0d results.",
                 n_sent, n_streams, n_checked);
        $display("Ran with no idling, sender gaps, receiver stalls and both; %0d mismatches.",
                 n_err);
        if (n_err == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

>>> sim.f
design/lzsd_pkg.sv
design/lzsd_if.sv
design/lzsd_ctrl.sv
design/lzsd_dpath.sv
design/lzss_stream_decompress_core.sv
design/lzsd_checker.sv
verif/lzss_stream_decompress_core_tb.sv
